// ===== sv/first_fit_segment_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// First-fit segment allocator assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FFSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("first fit allocator check failed");

// Next-cycle implication.
`define FFSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("first fit allocator check failed");

`endif

// ===== sv/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit segment allocator package
// Shared constants, segment entry type, codes and inter-module structs.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int OFFSET_BITS  = 16;
	localparam int OWNER_BITS   = 8;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int K_W          = IDX_W + 2;

	localparam logic [OFFSET_BITS-1:0] HEAP_RESET = OFFSET_BITS'(4096);

	typedef struct packed {
		logic                   is_free;
		logic [OWNER_BITS-1:0]  owner;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] len;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FIT    = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_e;

	typedef enum logic {
		UOP_ADD = 1'b0,
		UOP_SUB = 1'b1
	} uop_e;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_SPLIT_A,
		ST_SPLIT_B,
		ST_NEXT_RD,
		ST_NEXT_CHK,
		ST_PREV_RD,
		ST_PREV_CHK,
		ST_MERGE,
		ST_PULL_RD,
		ST_PULL_WR
	} state_e;

	typedef struct packed {
		uop_e                   op;
		logic [OFFSET_BITS-1:0] a;
		logic [OFFSET_BITS-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] res;
		logic                   ge;
		logic                   eq;
	} unit_rsp_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		seg_t             wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

// ===== sv/ffsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/ffsa_unit.sv =====
// ----------------------------------------------------------------------------
// Shared add/compare unit
// One adder that either adds or subtracts, with magnitude and equality flags.
// ----------------------------------------------------------------------------
module ffsa_unit import ffsa_pkg::*; (
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic [OFFSET_BITS:0]   sum;
	logic [OFFSET_BITS-1:0] b_op;

	always_comb begin
		b_op = (req.op == UOP_SUB) ? ~req.b : req.b;
		sum  = {1'b0, req.a} + {1'b0, b_op} + {{OFFSET_BITS{1'b0}}, (req.op == UOP_SUB)};
		rsp.res = sum[OFFSET_BITS-1:0];
		// On a subtract the carry out is set when a is not below b.
		rsp.ge  = sum[OFFSET_BITS];
		rsp.eq  = (sum[OFFSET_BITS-1:0] == '0);
	end

endmodule

// ===== sv/ffsa_seq.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the segment table in RAM, drives the shared unit, moves entries.
// ----------------------------------------------------------------------------
module ffsa_seq import ffsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   operation,
	input  logic [OWNER_BITS-1:0]  owner,
	input  logic [OFFSET_BITS-1:0] length,
	input  logic [OFFSET_BITS-1:0] offset,
	output logic                   done,
	output logic [1:0]             status,
	output logic [OFFSET_BITS-1:0] start_res,
	input  logic                   cfg_we,
	input  logic [OFFSET_BITS-1:0] cfg_wdata,
	output ram_req_t               ram_req,
	input  logic [SEG_W-1:0]       ram_rdata,
	output unit_req_t              unit_req,
	input  unit_rsp_t              unit_rsp
);

	state_e                 state_q, state_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [K_W-1:0]         k_q, k_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [OFFSET_BITS-1:0] heap_q;
	logic                   done_q, done_d;
	logic                   nfree_q, nfree_d;
	logic                   pfree_q, pfree_d;

	logic                   op_q;
	logic [OWNER_BITS-1:0]  owner_q;
	logic [OFFSET_BITS-1:0] len_q, ofs_q;
	seg_t                   cur_q, cur_d;
	logic [OFFSET_BITS-1:0] acc_start_q, acc_start_d;
	logic [OFFSET_BITS-1:0] acc_len_q, acc_len_d;
	logic [1:0]             status_q, status_d;
	logic [OFFSET_BITS-1:0] start_res_q, start_res_d;

	seg_t             rd;
	logic             accept;
	logic [CNT_W-1:0] idx_next;
	logic [1:0]       merge_cnt;
	logic [IDX_W-1:0] merge_pos;
	logic [K_W-1:0]   pull_from;
	logic [K_W-1:0]   k_minus_r;
	logic [K_W-1:0]   k_plus_1;

	assign rd        = seg_t'(ram_rdata);
	assign accept    = start && (state_q == ST_IDLE);
	assign idx_next  = CNT_W'(idx_q) + CNT_W'(1);
	assign merge_cnt = {1'b0, nfree_q} + {1'b0, pfree_q};
	assign merge_pos = idx_q - IDX_W'(pfree_q);
	assign pull_from = K_W'(merge_pos) + K_W'(1) + K_W'(merge_cnt);
	assign k_minus_r = k_q - K_W'(merge_cnt);
	assign k_plus_1  = k_q + K_W'(1);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		k_d         = k_q;
		count_d     = count_q;
		done_d      = 1'b0;
		nfree_d     = nfree_q;
		pfree_d     = pfree_q;
		cur_d       = cur_q;
		acc_start_d = acc_start_q;
		acc_len_d   = acc_len_q;
		status_d    = status_q;
		start_res_d = start_res_q;

		ram_req       = '0;
		ram_req.raddr = idx_q;
		unit_req.op   = UOP_SUB;
		unit_req.a    = rd.len;
		unit_req.b    = len_q;

		unique case (state_q)
			ST_INIT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = '0;
				ram_req.wdata = '{is_free: 1'b1, owner: '0, start: '0, len: heap_q};
				count_d       = CNT_W'(1);
				state_d       = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					idx_d = '0;
					if (operation == OP_ALLOC && length == '0) begin
						done_d      = 1'b1;
						status_d    = STAT_NO_FIT;
						start_res_d = '0;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cur_d = rd;
				if (op_q == OP_ALLOC) begin
					if (rd.is_free && unit_rsp.ge && unit_rsp.eq) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = idx_q;
						ram_req.wdata = '{is_free: 1'b0, owner: owner_q, start: rd.start,
							len: rd.len};
						done_d      = 1'b1;
						status_d    = STAT_OK;
						start_res_d = rd.start;
						state_d     = ST_IDLE;
					end else if (rd.is_free && unit_rsp.ge) begin
						// A split needs one more entry; the first fit decides.
						if (count_q == CNT_W'(MAX_SEGMENTS)) begin
							done_d      = 1'b1;
							status_d    = STAT_FULL;
							start_res_d = '0;
							state_d     = ST_IDLE;
						end else if (idx_next == count_q) begin
							state_d = ST_SPLIT_A;
						end else begin
							k_d     = K_W'(count_q) - K_W'(1);
							state_d = ST_SHIFT_RD;
						end
					end else if (idx_next == count_q) begin
						done_d      = 1'b1;
						status_d    = STAT_NO_FIT;
						start_res_d = '0;
						state_d     = ST_IDLE;
					end else begin
						idx_d   = idx_next[IDX_W-1:0];
						state_d = ST_READ;
					end
				end else begin
					if (!rd.is_free && rd.owner == owner_q && rd.start == ofs_q) begin
						acc_start_d = rd.start;
						acc_len_d   = rd.len;
						nfree_d     = 1'b0;
						pfree_d     = 1'b0;
						if (idx_next != count_q) begin
							state_d = ST_NEXT_RD;
						end else if (idx_q != '0) begin
							state_d = ST_PREV_RD;
						end else begin
							state_d = ST_MERGE;
						end
					end else if (idx_next == count_q) begin
						done_d      = 1'b1;
						status_d    = STAT_NOT_FOUND;
						start_res_d = '0;
						state_d     = ST_IDLE;
					end else begin
						idx_d   = idx_next[IDX_W-1:0];
						state_d = ST_READ;
					end
				end
			end
			ST_SHIFT_RD: begin
				ram_req.raddr = k_q[IDX_W-1:0];
				state_d       = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = k_plus_1[IDX_W-1:0];
				ram_req.wdata = rd;
				if (k_q == K_W'(idx_next)) begin
					state_d = ST_SPLIT_A;
				end else begin
					k_d     = k_q - K_W'(1);
					state_d = ST_SHIFT_RD;
				end
			end
			ST_SPLIT_A: begin
				unit_req.op   = UOP_ADD;
				unit_req.a    = cur_q.start;
				unit_req.b    = len_q;
				acc_start_d   = unit_rsp.res;
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q;
				ram_req.wdata = '{is_free: 1'b0, owner: owner_q, start: cur_q.start,
					len: len_q};
				state_d       = ST_SPLIT_B;
			end
			ST_SPLIT_B: begin
				unit_req.op   = UOP_SUB;
				unit_req.a    = cur_q.len;
				unit_req.b    = len_q;
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_next[IDX_W-1:0];
				ram_req.wdata = '{is_free: 1'b1, owner: '0, start: acc_start_q,
					len: unit_rsp.res};
				count_d       = count_q + CNT_W'(1);
				done_d        = 1'b1;
				status_d      = STAT_OK;
				start_res_d   = cur_q.start;
				state_d       = ST_IDLE;
			end
			ST_NEXT_RD: begin
				ram_req.raddr = idx_next[IDX_W-1:0];
				state_d       = ST_NEXT_CHK;
			end
			ST_NEXT_CHK: begin
				unit_req.op = UOP_ADD;
				unit_req.a  = acc_len_q;
				unit_req.b  = rd.len;
				if (rd.is_free) begin
					nfree_d   = 1'b1;
					acc_len_d = unit_rsp.res;
				end
				state_d = (idx_q != '0) ? ST_PREV_RD : ST_MERGE;
			end
			ST_PREV_RD: begin
				ram_req.raddr = idx_q - IDX_W'(1);
				state_d       = ST_PREV_CHK;
			end
			ST_PREV_CHK: begin
				unit_req.op = UOP_ADD;
				unit_req.a  = acc_len_q;
				unit_req.b  = rd.len;
				if (rd.is_free) begin
					pfree_d     = 1'b1;
					acc_len_d   = unit_rsp.res;
					acc_start_d = rd.start;
				end
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = merge_pos;
				ram_req.wdata = '{is_free: 1'b1, owner: '0, start: acc_start_q,
					len: acc_len_q};
				if (merge_cnt == 2'd0) begin
					done_d      = 1'b1;
					status_d    = STAT_OK;
					start_res_d = '0;
					state_d     = ST_IDLE;
				end else if (pull_from >= K_W'(count_q)) begin
					count_d     = count_q - CNT_W'(merge_cnt);
					done_d      = 1'b1;
					status_d    = STAT_OK;
					start_res_d = '0;
					state_d     = ST_IDLE;
				end else begin
					k_d     = pull_from;
					state_d = ST_PULL_RD;
				end
			end
			ST_PULL_RD: begin
				ram_req.raddr = k_q[IDX_W-1:0];
				state_d       = ST_PULL_WR;
			end
			ST_PULL_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = k_minus_r[IDX_W-1:0];
				ram_req.wdata = rd;
				if (k_plus_1 == K_W'(count_q)) begin
					count_d     = count_q - CNT_W'(merge_cnt);
					done_d      = 1'b1;
					status_d    = STAT_OK;
					start_res_d = '0;
					state_d     = ST_IDLE;
				end else begin
					k_d     = k_plus_1;
					state_d = ST_PULL_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// A heap length write rebuilds the table as one free segment.
		if (cfg_we) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = '0;
			ram_req.wdata = '{is_free: 1'b1, owner: '0, start: '0, len: cfg_wdata};
			count_d       = CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			idx_q   <= '0;
			k_q     <= '0;
			count_q <= CNT_W'(1);
			heap_q  <= HEAP_RESET;
			done_q  <= 1'b0;
			nfree_q <= 1'b0;
			pfree_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			k_q     <= k_d;
			count_q <= count_d;
			done_q  <= done_d;
			nfree_q <= nfree_d;
			pfree_q <= pfree_d;
			if (cfg_we) begin
				heap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			owner_q <= owner;
			len_q   <= length;
			ofs_q   <= offset;
		end
		cur_q       <= cur_d;
		acc_start_q <= acc_start_d;
		acc_len_q   <= acc_len_d;
		status_q    <= status_d;
		start_res_q <= start_res_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign start_res = start_res_q;

endmodule

// ===== sv/first_fit_segment_allocator_top.sv =====
// A zero-length allocate pulses done in the cycle after start; otherwise each table
// entry scanned is read and then checked, and each entry moved for a split or merge
// is read and then written. One request at a time: busy stays high until done is
// pulsed, except for a zero-length allocate, which never raises busy.
// After reset the block writes the initial free segment in its init state (busy).
// Results cannot be stalled: done marks a one-cycle transfer.
// ----------------------------------------------------------------------------
// First-fit segment allocator
// Ordered segment table in RAM, walked by a sequencer with one shared adder.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_top import ffsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   operation,
	input  logic [OWNER_BITS-1:0]  owner,
	input  logic [OFFSET_BITS-1:0] length,
	input  logic [OFFSET_BITS-1:0] offset,
	output logic                   done,
	output logic [1:0]             status,
	output logic [OFFSET_BITS-1:0] start_res,
	input  logic                   cfg_we,
	input  logic [OFFSET_BITS-1:0] cfg_wdata
);

	ram_req_t         ram_req;
	logic [SEG_W-1:0] ram_rdata;
	unit_req_t        unit_req;
	unit_rsp_t        unit_rsp;

	ffsa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.owner     (owner),
		.length    (length),
		.offset    (offset),
		.done      (done),
		.status    (status),
		.start_res (start_res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.unit_req  (unit_req),
		.unit_rsp  (unit_rsp)
	);

	ffsa_ram #(
		.WIDTH (SEG_W),
		.DEPTH (MAX_SEGMENTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	ffsa_unit u_unit (
		.req (unit_req),
		.rsp (unit_rsp)
	);

endmodule

// ===== sv/ffsa_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit segment allocator port checker
// Watches the top-level ports and checks request and result sequencing.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_top_assert.svh"

module ffsa_checker import ffsa_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [1:0]             status,
	input logic [OFFSET_BITS-1:0] start_res
);

	// An accepted request either completes at once or keeps the block busy.
	`FFSA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)

	// A failed request never reports a start offset; this check does not cover frees.
	`FFSA_ASSERT_IMP(a_fail_zero_start, done && status != STAT_OK, start_res == '0)

	// A result transfer only follows an accepted request or a busy cycle.
	`FFSA_ASSERT_IMP(a_done_has_cause, done, $past(busy || start))

endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.start_res (start_res)
);
